// File: rtl/uart_8n1_tick_transceiver_assert.svh
// assertion macros shared by the uart transceiver rtl
// expects the including module to supply the clock and reset names as arguments
`ifndef UART_8N1_TICK_TRANSCEIVER_ASSERT_SVH
`define UART_8N1_TICK_TRANSCEIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/utt_pkg.sv
// shared types for the tick-driven 8n1 uart transceiver
// no dependencies
`default_nettype none

package utt_pkg;

    typedef enum logic [2:0] {
        REQ_RX_EDGE   = 3'd0,
        REQ_RX_SAMPLE = 3'd1,
        REQ_TX_TICK   = 3'd2,
        REQ_TX_LOAD   = 3'd3,
        REQ_READ      = 3'd4
    } req_t;

    localparam logic [3:0] STEP_START = 4'd1;
    localparam logic [3:0] STEP_DATA0 = 4'd2;
    localparam logic [3:0] STEP_DATA7 = 4'd9;
    localparam logic [3:0] STEP_STOP  = 4'd10;

    typedef struct packed {
        logic       busy;
        logic       ready;
        logic [7:0] data;
        logic       overrun;
    } rx_status_t;

    typedef struct packed {
        logic line;
        logic busy;
        logic load_accepted;
    } tx_status_t;

endpackage

`default_nettype wire

// File: rtl/utt_req_if.sv
// input channel of the uart transceiver: one event word per handshake
// no dependencies
`default_nettype none

interface utt_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic       rx_level;
    logic [7:0] tx_byte;

    modport source (output valid, output req_type, output rx_level, output tx_byte,
                    input ready);
    modport sink   (input valid, input req_type, input rx_level, input tx_byte,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/utt_rsp_if.sv
// result channel of the uart transceiver: one status word per handshake
// no dependencies
`default_nettype none

interface utt_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       tx_busy;
    logic       rx_busy;
    logic       rx_ready;
    logic [7:0] rx_data;
    logic       overrun;
    logic       load_accepted;

    modport source (output valid, output tx_line, output tx_busy, output rx_busy,
                    output rx_ready, output rx_data, output overrun,
                    output load_accepted, input ready);
    modport sink   (input valid, input tx_line, input tx_busy, input rx_busy,
                    input rx_ready, input rx_data, input overrun,
                    input load_accepted, output ready);
endinterface

`default_nettype wire

// File: rtl/utt_rx.sv
// receiver state of the uart transceiver, advanced once per event word
// depends on utt_pkg
`default_nettype none

module utt_rx
    import utt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire req_t       req,
    input  wire logic       level,
    output rx_status_t      status
);

    logic       active_reg, active_next;
    logic [3:0] step_reg, step_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] hold_reg, hold_next;
    logic       full_reg, full_next;
    logic       ovr_reg, ovr_next;
    logic [3:0] step_inc;
    logic [2:0] bit_idx;

    assign step_inc = step_reg + 4'd1;
    assign bit_idx  = 3'(step_inc - STEP_DATA0);

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        shift_next  = shift_reg;
        hold_next   = hold_reg;
        full_next   = full_reg;
        ovr_next    = ovr_reg;
        case (req)
            REQ_RX_EDGE:
            begin
                if (!active_reg)
                begin
                    active_next = 1'b1;
                    step_next   = 4'd0;
                end
            end
            REQ_RX_SAMPLE:
            begin
                if (active_reg)
                begin
                    step_next = step_inc;
                    if (step_inc == STEP_START)
                    begin
                        shift_next = 8'd0;
                        if (level)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            // previous byte never read
                            if (full_reg)
                            begin
                                ovr_next = 1'b1;
                            end
                            full_next = 1'b0;
                        end
                    end
                    else if (step_inc inside {[STEP_DATA0:STEP_DATA7]})
                    begin
                        if (level)
                        begin
                            shift_next[bit_idx] = 1'b1;
                        end
                    end
                    else
                    begin
                        if (step_inc == STEP_STOP)
                        begin
                            full_next = 1'b1;
                            hold_next = shift_reg;
                        end
                        active_next = 1'b0;
                    end
                end
            end
            REQ_READ:
            begin
                full_next = 1'b0;
                ovr_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // a read reports the flags as they were before clearing
    always_comb
    begin
        status.busy = active_next;
        status.data = hold_next;
        if (req == REQ_READ)
        begin
            status.ready   = full_reg;
            status.overrun = ovr_reg;
        end
        else
        begin
            status.ready   = full_next;
            status.overrun = ovr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= 4'd0;
            shift_reg  <= 8'd0;
            hold_reg   <= 8'd0;
            full_reg   <= 1'b0;
            ovr_reg    <= 1'b0;
        end
        else if (en)
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            shift_reg  <= shift_next;
            hold_reg   <= hold_next;
            full_reg   <= full_next;
            ovr_reg    <= ovr_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/utt_tx.sv
// transmitter state of the uart transceiver, advanced once per event word
// depends on utt_pkg and the assertion macro header
`default_nettype none

`include "uart_8n1_tick_transceiver_assert.svh"

module utt_tx
    import utt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire req_t       req,
    input  wire logic [7:0] tx_byte,
    output tx_status_t      status
);

    logic       active_reg, active_next;
    logic [3:0] step_reg, step_next;
    logic [7:0] shift_reg, shift_next;
    logic       line_reg, line_next;
    logic       accepted;
    logic [3:0] step_inc;
    logic [2:0] bit_idx;

    assign step_inc = step_reg + 4'd1;
    assign bit_idx  = 3'(step_inc - STEP_DATA0);

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        shift_next  = shift_reg;
        line_next   = line_reg;
        accepted    = 1'b0;
        case (req)
            REQ_TX_TICK:
            begin
                if (active_reg)
                begin
                    step_next = step_inc;
                    if (step_inc == STEP_START)
                    begin
                        line_next = 1'b0;
                    end
                    else if (step_inc inside {[STEP_DATA0:STEP_DATA7]})
                    begin
                        line_next = shift_reg[bit_idx];
                    end
                    else if (step_inc == STEP_STOP)
                    begin
                        line_next = 1'b1;
                    end
                    else
                    begin
                        // idle one tick after the stop bit
                        active_next = 1'b0;
                    end
                end
            end
            REQ_TX_LOAD:
            begin
                if (!active_reg)
                begin
                    shift_next  = tx_byte;
                    step_next   = 4'd0;
                    active_next = 1'b1;
                    accepted    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.line          = line_next;
        status.busy          = active_next;
        status.load_accepted = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= 4'd0;
            shift_reg  <= 8'd0;
            line_reg   <= 1'b1;
        end
        else if (en)
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            shift_reg  <= shift_next;
            line_reg   <= line_next;
        end
    end

    `UTT_ASSERT_IMP(a_idle_line_high, clk, rst_n, !active_reg, line_reg, "tx idle with line low")
    `UTT_ASSERT_IMP(a_step_in_frame, clk, rst_n, active_reg, step_reg <= STEP_STOP, "tx step past frame")
    `UTT_ASSERT_NXT(a_load_starts, clk, rst_n, en && accepted, active_reg && step_reg == 4'd0, "tx load lost")

endmodule

`default_nettype wire

// File: rtl/uart_8n1_tick_transceiver.sv
// an event word waits in the input register until the result register is free
// or drained; throughput: one event word per cycle while the result is not stalled;
// the receiver and transmitter state update between the input and result registers
// reset: rst_n clears all control state, the transmit line resets high
// depends on utt_pkg, utt_req_if, utt_rsp_if, utt_rx, utt_tx and the assertion header
`default_nettype none

`include "uart_8n1_tick_transceiver_assert.svh"

module uart_8n1_tick_transceiver
    import utt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    utt_req_if.sink    req_ch,
    utt_rsp_if.source  rsp_ch
);

    logic       in_valid_reg;
    logic [2:0] req_type_reg;
    logic       rx_level_reg;
    logic [7:0] tx_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       adv;
    req_t       req;
    rx_status_t rx_stat, rx_stat_reg;
    tx_status_t tx_stat, tx_stat_reg;

    // advance when the result register is free or being drained
    assign adv          = in_valid_reg && (!out_valid_reg || rsp_ch.ready);
    assign req_ch.ready = !in_valid_reg || adv;
    assign req          = req_t'(req_type_reg);

    utt_rx u_rx (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .req    (req),
        .level  (rx_level_reg),
        .status (rx_stat)
    );

    utt_tx u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .req     (req),
        .tx_byte (tx_byte_reg),
        .status  (tx_stat)
    );

    always_comb
    begin
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ch.ready)
            begin
                in_valid_reg <= req_ch.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.valid && req_ch.ready)
        begin
            req_type_reg <= req_ch.req_type;
            rx_level_reg <= req_ch.rx_level;
            tx_byte_reg  <= req_ch.tx_byte;
        end
        if (adv)
        begin
            rx_stat_reg <= rx_stat;
            tx_stat_reg <= tx_stat;
        end
    end

    assign rsp_ch.valid         = out_valid_reg;
    assign rsp_ch.tx_line       = tx_stat_reg.line;
    assign rsp_ch.tx_busy       = tx_stat_reg.busy;
    assign rsp_ch.load_accepted = tx_stat_reg.load_accepted;
    assign rsp_ch.rx_busy       = rx_stat_reg.busy;
    assign rsp_ch.rx_ready      = rx_stat_reg.ready;
    assign rsp_ch.rx_data       = rx_stat_reg.data;
    assign rsp_ch.overrun       = rx_stat_reg.overrun;

    `UTT_ASSERT_IMP(a_stall_only_full, clk, rst_n, !req_ch.ready, in_valid_reg && out_valid_reg && !rsp_ch.ready, "input stalled with room")
    `UTT_ASSERT_NXT(a_adv_gives_word, clk, rst_n, adv, out_valid_reg, "advanced word not presented")
    `UTT_ASSERT_IMP(a_load_busy, clk, rst_n, out_valid_reg && tx_stat_reg.load_accepted, tx_stat_reg.busy, "accepted load without busy")

endmodule

`default_nettype wire

// File: tb/uart_8n1_tick_transceiver_tb.sv
// testbench for the tick-driven 8n1 uart transceiver: a directed table, then random event words
// checked word by word against a local model of the receiver and transmitter
// depends on utt_pkg, utt_req_if, utt_rsp_if and uart_8n1_tick_transceiver
module uart_8n1_tick_transceiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utt_pkg::*;

    // request codes the block decodes to no action
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 1000;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       rx_busy;
        logic       rx_ready;
        logic [7:0] rx_data;
        logic       overrun;
        logic       load_accepted;
    } uart_status_t;

    typedef struct packed {
        logic [2:0]   req;
        logic         level;
        logic [7:0]   data;
        logic         typed;
        uart_status_t want;
    } stim_row_t;

    localparam uart_status_t STATUS_IDLE    = '{tx_line: 1'b1, default: '0};
    localparam uart_status_t STATUS_TX_BUSY = '{tx_line: 1'b1, tx_busy: 1'b1, default: '0};
    localparam uart_status_t STATUS_LOADED  = '{tx_line: 1'b1, tx_busy: 1'b1,
                                                load_accepted: 1'b1, default: '0};

    localparam int STIM_ROWS = 25;

    // 8'ha5 goes in lsb first: 1 0 1 0 0 1 0 1
    stim_row_t stim_rows [STIM_ROWS] = '{
        '{REQ_READ,      1'b0, 8'h00, 1'b1, STATUS_IDLE},
        '{REQ_SPARE_HI,  1'b1, 8'hff, 1'b1, STATUS_IDLE},
        '{REQ_TX_TICK,   1'b0, 8'h00, 1'b1, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b1, 8'h00, 1'b1, STATUS_IDLE},
        '{REQ_TX_LOAD,   1'b0, 8'hff, 1'b1, STATUS_LOADED},
        '{REQ_TX_LOAD,   1'b1, 8'h00, 1'b1, STATUS_TX_BUSY},
        '{REQ_RX_EDGE,   1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_EDGE,   1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b1, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_EDGE,   1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b1, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b1, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b1, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b1, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_EDGE,   1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_RX_SAMPLE, 1'b0, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_READ,      1'b1, 8'h00, 1'b0, STATUS_IDLE},
        '{REQ_SPARE_LO,  1'b0, 8'h5a, 1'b0, STATUS_IDLE},
        '{REQ_TX_TICK,   1'b1, 8'h00, 1'b0, STATUS_IDLE}
    };

    logic clk = 1'b0;
    logic rst_n;

    utt_req_if req_ch ();
    utt_rsp_if rsp_ch ();

    uart_8n1_tick_transceiver DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .rsp_ch (rsp_ch)
    );

    // model of the transceiver state
    logic       rx_on    = 1'b0;
    logic [3:0] rx_step  = '0;
    logic [7:0] rx_sh    = '0;
    logic [7:0] rx_held  = '0;
    logic       rx_full  = 1'b0;
    logic       ovr_seen = 1'b0;
    logic       tx_on    = 1'b0;
    logic [3:0] tx_step  = '0;
    logic [7:0] tx_sh    = '0;
    logic       line_lvl = 1'b1;

    uart_status_t status_due [$];
    int mismatch_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic uart_status_t uart_next_status(logic [2:0] req, logic level,
                                                      logic [7:0] data);
        uart_status_t st;
        st = '0;
        case (req)
            REQ_RX_EDGE:
            begin
                if (!rx_on)
                begin
                    rx_on   = 1'b1;
                    rx_step = '0;
                end
            end
            REQ_RX_SAMPLE:
            begin
                if (rx_on)
                begin
                    rx_step = rx_step + 4'd1;
                    if (rx_step == STEP_START)
                    begin
                        rx_sh = '0;
                        // a high start bit drops the frame, flags stay as they are
                        if (level)
                            rx_on = 1'b0;
                        else
                        begin
                            if (rx_full)
                                ovr_seen = 1'b1;
                            rx_full = 1'b0;
                        end
                    end
                    else if (rx_step >= STEP_DATA0 && rx_step <= STEP_DATA7)
                    begin
                        if (level)
                            rx_sh[3'(rx_step - STEP_DATA0)] = 1'b1;
                    end
                    else
                    begin
                        // stop bit level is not checked
                        if (rx_step == STEP_STOP)
                        begin
                            rx_full = 1'b1;
                            rx_held = rx_sh;
                        end
                        rx_on = 1'b0;
                    end
                end
            end
            REQ_TX_TICK:
            begin
                if (tx_on)
                begin
                    tx_step = tx_step + 4'd1;
                    if (tx_step == STEP_START)
                        line_lvl = 1'b0;
                    else if (tx_step >= STEP_DATA0 && tx_step <= STEP_DATA7)
                        line_lvl = tx_sh[3'(tx_step - STEP_DATA0)];
                    else if (tx_step == STEP_STOP)
                        line_lvl = 1'b1;
                    else
                        tx_on = 1'b0;
                end
            end
            REQ_TX_LOAD:
            begin
                if (!tx_on)
                begin
                    tx_sh   = data;
                    tx_step = '0;
                    tx_on   = 1'b1;
                    st.load_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        st.tx_line  = line_lvl;
        st.tx_busy  = tx_on;
        st.rx_busy  = rx_on;
        st.rx_ready = rx_full;
        st.rx_data  = rx_held;
        st.overrun  = ovr_seen;
        if (req == REQ_READ)
        begin
            rx_full  = 1'b0;
            ovr_seen = 1'b0;
        end
        return st;
    endfunction

    task automatic send_word(input logic [2:0] req, input logic level, input logic [7:0] data,
                             input logic typed, input uart_status_t want);
        uart_status_t due;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req;
        req_ch.rx_level <= level;
        req_ch.tx_byte  <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        due = uart_next_status(req, level, data);
        status_due.push_back(typed ? want : due);
    endtask

    // mostly whole frames: edges while idle, low start bits, ticks and loads, few reads
    task automatic send_random_word();
        logic [2:0] req;
        logic       level;
        logic [7:0] data;
        int         pick;
        level = 1'($urandom_range(0, 1));
        data  = 8'($urandom_range(0, 255));
        pick  = $urandom_range(0, 99);
        if (!rx_on && pick < 25)
            req = REQ_RX_EDGE;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
            else if (pick < 8)
                req = REQ_RX_EDGE;
            else if (pick < 50)
                req = REQ_RX_SAMPLE;
            else if (pick < 78)
                req = REQ_TX_TICK;
            else if (pick < 88)
                req = REQ_TX_LOAD;
            else if (pick < 94)
                req = REQ_READ;
            else
                req = REQ_RX_SAMPLE;
            // start bit mostly low so frames get through
            if (req == REQ_RX_SAMPLE && rx_on && rx_step == 4'd0)
                level = ($urandom_range(0, 9) == 0);
        end
        send_word(req, level, data, 1'b0, '0);
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        uart_status_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (status_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("status word with none expected: rx_data %0h", rsp_ch.rx_data);
            end
            else
            begin
                want = status_due.pop_front();
                check_field("tx_line", 8'(want.tx_line), 8'(rsp_ch.tx_line));
                check_field("tx_busy", 8'(want.tx_busy), 8'(rsp_ch.tx_busy));
                check_field("rx_busy", 8'(want.rx_busy), 8'(rsp_ch.rx_busy));
                check_field("rx_ready", 8'(want.rx_ready), 8'(rsp_ch.rx_ready));
                check_field("rx_data", want.rx_data, rsp_ch.rx_data);
                check_field("overrun", 8'(want.overrun), 8'(rsp_ch.overrun));
                check_field("load_accepted", 8'(want.load_accepted),
                            8'(rsp_ch.load_accepted));
            end
        end
    end

    initial
    begin
        int ph;
        int k;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_READ;
        req_ch.rx_level <= 1'b0;
        req_ch.tx_byte  <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (stim_rows[i])
            send_word(stim_rows[i].req, stim_rows[i].level, stim_rows[i].data,
                      stim_rows[i].typed, stim_rows[i].want);
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 65; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 65; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase
            for (k = 0; k < RANDOM_WORDS / PHASES; k++)
                send_random_word();
            // hold off until every status word is back
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while (status_due.size() != 0);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
